FILE: sv/fqs_pkg.sv
// fqs_pkg: shared types and codes of the fifo queue with membership search
// request codes, result status codes and controller states
// no dependencies
package fqs_pkg;

	typedef enum logic [1:0] {
		REQ_ENQUEUE  = 2'd0,
		REQ_DEQUEUE  = 2'd1,
		REQ_PEEK     = 2'd2,
		REQ_CONTAINS = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN
	} state_t;

endpackage

FILE: sv/fifo_queue_with_search.sv
// fifo_queue_with_search: ring-buffer fifo with dequeue, peek and membership search
// entries sit in one synchronous memory with a registered read port
// depends on fqs_pkg
//
//  channel | signals                             | direction | role
//  --------+-------------------------------------+-----------+------------------------------
//  request | in_valid, in_stall, req_type, value | in        | one operation per transaction
//  result  | out_valid, out_stall, data_out,     | out       | one result per request
//          | found, status, count                |           |
//
// enqueue, full and empty cases load the result on acceptance; dequeue and peek
// first pass through ST_READ for the registered memory read; contains walks one entry per
// cycle through the single memory read port, and stops early on a match.
// reset clears head, tail, count and the controller; entry contents stay
// undefined until written, no clearing pass is needed.
// in_stall is high while a request is in work or the result register holds
// a result that the sink is stalling.
module fifo_queue_with_search
	import fqs_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] value,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] data_out,
	output logic        found,
	output logic [1:0]  status,
	output logic [4:0]  count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [DATA_WIDTH-1:0] WORD_ONES = '1;

	// ring pointer step, wraps at DEPTH also for non power of two depths
	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		ring_next = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// entry memory and its registered read port
	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_s1;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;

	// queue bookkeeping
	logic [AW-1:0] head_q, head_d;
	logic [AW-1:0] tail_q, tail_d;
	logic [CW-1:0] cnt_q, cnt_d;

	// search walk
	logic [AW-1:0]         scan_ptr_q, scan_ptr_d;
	logic [CW-1:0]         scan_left_q, scan_left_d;
	logic [DATA_WIDTH-1:0] key_q, key_d;
	logic                  cmp_valid_s1, scan_issue, scan_hit;

	state_t state_q, state_d;

	// result register
	logic                  res_load;
	logic [31:0]           res_data;
	logic                  res_found;
	status_t               res_status;
	logic [CW-1:0]         res_count;
	logic                  out_valid_q;
	logic [31:0]           data_out_q;
	logic                  found_q;
	status_t               status_q;
	logic [4:0]            count_q;

	req_t                  req;
	logic                  accept;
	logic                  q_empty, q_full;
	logic [DATA_WIDTH-1:0] word_in;

	assign req     = req_t'(req_type);
	assign word_in = DATA_WIDTH'(value);
	assign q_empty = (cnt_q == '0);
	assign q_full  = (cnt_q == CW'(DEPTH));

	// a new request only enters when idle and the result slot can take a result
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	assign scan_issue = (state_q == ST_SCAN) && (scan_left_q != '0);
	assign scan_hit   = cmp_valid_s1 && (rd_data_s1 == key_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !q_empty) begin
					if (req == REQ_DEQUEUE || req == REQ_PEEK) begin
						state_d = ST_READ;
					end else if (req == REQ_CONTAINS) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (scan_hit || (scan_left_q == '0 && cmp_valid_s1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath and result controls
	always_comb begin
		head_d      = head_q;
		tail_d      = tail_q;
		cnt_d       = cnt_q;
		scan_ptr_d  = scan_ptr_q;
		scan_left_d = scan_left_q;
		key_d       = key_q;
		wr_en       = 1'b0;
		rd_addr     = head_q;
		res_load    = 1'b0;
		res_data    = '0;
		res_found   = 1'b0;
		res_status  = STAT_OK;
		res_count   = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (req == REQ_ENQUEUE) begin
						res_load = 1'b1;
						if (q_full) begin
							res_status = STAT_FULL;
						end else begin
							wr_en     = 1'b1;
							tail_d    = ring_next(tail_q);
							cnt_d     = cnt_q + 1'b1;
							res_count = cnt_q + 1'b1;
						end
					end else if (q_empty) begin
						res_load   = 1'b1;
						res_status = STAT_EMPTY;
						res_data   = 32'(WORD_ONES);
					end else if (req == REQ_DEQUEUE) begin
						// head read issued now, data lands in rd_data_s1
						head_d = ring_next(head_q);
						cnt_d  = cnt_q - 1'b1;
					end else if (req == REQ_CONTAINS) begin
						scan_ptr_d  = head_q;
						scan_left_d = cnt_q;
						key_d       = word_in;
					end else begin
						// peek: read only
					end
				end
			end
			ST_READ: begin
				res_load = 1'b1;
				res_data = 32'(rd_data_s1);
			end
			ST_SCAN: begin
				rd_addr = scan_ptr_q;
				if (scan_issue) begin
					scan_ptr_d  = ring_next(scan_ptr_q);
					scan_left_d = scan_left_q - 1'b1;
				end
				if (scan_hit) begin
					res_load  = 1'b1;
					res_found = 1'b1;
				end else if (scan_left_q == '0 && cmp_valid_s1) begin
					res_load = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// entry memory: one write port, one read port with registered data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= word_in;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			cnt_q        <= '0;
			scan_left_q  <= '0;
			cmp_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			head_q       <= head_d;
			tail_q       <= tail_d;
			cnt_q        <= cnt_d;
			scan_left_q  <= scan_left_d;
			// a scan read issued this cycle is compared next cycle
			cmp_valid_s1 <= scan_issue && !scan_hit;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		scan_ptr_q <= scan_ptr_d;
		key_q      <= key_d;
		if (res_load) begin
			data_out_q <= res_data;
			found_q    <= res_found;
			status_q   <= res_status;
			count_q    <= 5'(res_count);
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign found     = found_q;
	assign status    = status_q;
	assign count     = count_q;

endmodule

FILE: verif/tb.sv
// tb: self-checking bench for fifo_queue_with_search over its request and result channels
// a behavioral queue model or a typed table row gives each result, scored field by field
// depends on fqs_pkg and fifo_queue_with_search
module tb;
	import fqs_pkg::*;

	localparam int          DEPTH           = 16;
	localparam int          DATA_WIDTH      = 32;
	localparam int unsigned RANDOM_ITEMS    = 1200;
	localparam int unsigned HOLD_OFF_CYCLES = 150;
	// contains scans one entry per cycle, so the tail wait covers a full scan twice over
	localparam int unsigned TAIL_CYCLES     = 40;
	localparam int unsigned CYCLE_LIMIT     = 400000;

	// one result transaction as the block reports it
	typedef struct packed {
		logic [31:0] data;
		logic        found;
		status_t     status;
		logic [4:0]  count;
	} result_t;

	// one row of the opening table; reps > 1 repeats the request with random words
	typedef struct {
		req_t        op;
		logic [31:0] word;
		int unsigned reps;
		bit          typed;
		result_t     want;
	} stim_row_t;

	// request mixes that steer the queue toward full, toward empty, or keep it level
	typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	// stall patterns of the result sink
	typedef enum {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} sink_mode_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type  = REQ_ENQUEUE;
	logic [31:0] value     = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] data_out;
	logic        found;
	logic [1:0]  status;
	logic [4:0]  count;

	// model of the ring: oldest word at index 0
	logic [31:0] held_words [$];
	// results predicted for accepted requests, oldest first
	result_t     pending_responses [$];

	int unsigned fail_count      = 0;
	int unsigned cycle_count     = 0;
	int unsigned burst_left      = 0;
	int unsigned hold_offs_asked = 0;
	int unsigned hold_offs_done  = 0;

	// opening table: empty-queue cases, word extremes, filling to full, a full enqueue,
	// a deep search and dequeues that read back the extremes
	stim_row_t opening_rows [12] = '{
		'{REQ_DEQUEUE,  32'h0000_0000, 1,  1'b1, '{32'hFFFF_FFFF, 1'b0, STAT_EMPTY, 5'd0}},
		'{REQ_PEEK,     32'h0000_0000, 1,  1'b1, '{32'hFFFF_FFFF, 1'b0, STAT_EMPTY, 5'd0}},
		'{REQ_CONTAINS, 32'h0000_0000, 1,  1'b1, '{32'hFFFF_FFFF, 1'b0, STAT_EMPTY, 5'd0}},
		'{REQ_ENQUEUE,  32'h0000_0000, 1,  1'b1, '{32'h0000_0000, 1'b0, STAT_OK,    5'd1}},
		'{REQ_ENQUEUE,  32'hFFFF_FFFF, 1,  1'b1, '{32'h0000_0000, 1'b0, STAT_OK,    5'd2}},
		'{REQ_PEEK,     32'h0000_0000, 1,  1'b1, '{32'h0000_0000, 1'b0, STAT_OK,    5'd2}},
		'{REQ_CONTAINS, 32'hFFFF_FFFF, 1,  1'b1, '{32'h0000_0000, 1'b1, STAT_OK,    5'd2}},
		'{REQ_ENQUEUE,  32'h0000_0000, 14, 1'b0, '{32'h0000_0000, 1'b0, STAT_OK,    5'd0}},
		'{REQ_ENQUEUE,  32'hAAAA_AAAA, 1,  1'b1, '{32'h0000_0000, 1'b0, STAT_FULL,  5'd16}},
		'{REQ_CONTAINS, 32'h5555_5555, 1,  1'b0, '{32'h0000_0000, 1'b0, STAT_OK,    5'd0}},
		'{REQ_DEQUEUE,  32'h0000_0000, 1,  1'b1, '{32'h0000_0000, 1'b0, STAT_OK,    5'd15}},
		'{REQ_DEQUEUE,  32'h0000_0000, 1,  1'b1, '{32'hFFFF_FFFF, 1'b0, STAT_OK,    5'd14}}
	};

	fifo_queue_with_search #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_out  (data_out),
		.found     (found),
		.status    (status),
		.count     (count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// applies one request to the queue model and returns the result it must produce
	function automatic result_t fifo_response(req_t op, logic [31:0] word);
		result_t r;
		r = '{data: '0, found: 1'b0, status: STAT_OK, count: '0};
		if (op == REQ_ENQUEUE) begin
			// a full queue drops the word and leaves everything as it was
			if (held_words.size() >= DEPTH)
				r.status = STAT_FULL;
			else
				held_words.push_back(word);
		end else if (held_words.size() == 0) begin
			// dequeue, peek and contains on an empty queue all report empty
			r.status = STAT_EMPTY;
			r.data   = '1;
		end else begin
			case (op)
				REQ_DEQUEUE: r.data = held_words.pop_front();
				REQ_PEEK:    r.data = held_words[0];
				default: begin
					foreach (held_words[i])
						if (held_words[i] == word)
							r.found = 1'b1;
				end
			endcase
		end
		r.count = 5'(held_words.size());
		return r;
	endfunction

	function automatic req_t pick_request(mix_t mix);
		int unsigned roll;
		int unsigned enq_pct;
		int unsigned deq_pct;
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				enq_pct = 60;
				deq_pct = 15;
			end
			MIX_DRAIN: begin
				enq_pct = 15;
				deq_pct = 60;
			end
			default: begin
				enq_pct = 35;
				deq_pct = 30;
			end
		endcase
		if (roll < enq_pct)
			return REQ_ENQUEUE;
		if (roll < enq_pct + deq_pct)
			return REQ_DEQUEUE;
		if (roll < enq_pct + deq_pct + 10)
			return REQ_PEEK;
		return REQ_CONTAINS;
	endfunction

	// half the searches look for a word that is held, so matches land at every depth;
	// small words make duplicates common
	function automatic logic [31:0] pick_word(req_t op);
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (op == REQ_CONTAINS && held_words.size() != 0 && roll < 5)
			return held_words[$urandom_range(0, held_words.size() - 1)];
		if (roll == 5)
			return '0;
		if (roll == 6)
			return '1;
		if (roll == 7)
			return 32'($urandom_range(0, 7));
		return $urandom();
	endfunction

	// offers one request and holds it until the block takes the transaction
	task automatic offer(input req_t op, input logic [31:0] word, input bit typed,
			input result_t typed_want);
		result_t predicted;
		in_valid <= 1'b1;
		req_type <= op;
		value    <= word;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		predicted = fifo_response(op, word);
		pending_responses.push_back(typed ? typed_want : predicted);
	endtask

	// drops valid with junk on the payload; n gives the length of the idle stretch
	task automatic idle_cycles(input int unsigned n);
		in_valid <= 1'b0;
		repeat (n) begin
			req_type <= 2'($urandom_range(0, 3));
			value    <= $urandom();
			@(posedge clk);
		end
	endtask

	// bursts of random length, some long, with random gaps between them
	task automatic pace();
		if (burst_left == 0) begin
			idle_cycles($urandom_range(1, 12));
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 20);
		end else begin
			burst_left--;
		end
	endtask

	// holds off requests until every predicted result has come back
	task automatic settle();
		idle_cycles(1);
		while (pending_responses.size() != 0)
			@(posedge clk);
	endtask

	// request source: reset, the opening table, then the random part
	initial begin : request_source
		mix_t        mix;
		int unsigned mix_left;
		req_t        op;
		mix_left = 0;
		mix      = MIX_EVEN;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_rows[r]) begin
			repeat (opening_rows[r].reps) begin
				offer(opening_rows[r].op,
					(opening_rows[r].reps > 1) ? $urandom() : opening_rows[r].word,
					opening_rows[r].typed, opening_rows[r].want);
				pace();
			end
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// ask the sink for a long hold-off while requests keep coming
			if (n % 400 == 10)
				hold_offs_asked++;
			// now and then let the queue go fully quiet
			if (n % 300 == 200)
				settle();
			if (mix_left == 0) begin
				mix      = mix_t'($urandom_range(0, 2));
				mix_left = $urandom_range(10, 80);
			end
			mix_left--;
			op = pick_request(mix);
			offer(op, pick_word(op), 1'b0, '0);
			pace();
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_responses.size() != 0) begin
			$error("%0d results never arrived", pending_responses.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// result sink: runs of random length in one stall pattern each, plus long
	// hold-offs on request so the block fills and stalls its input
	initial begin : result_sink
		sink_mode_t  mode;
		int unsigned run_len;
		int unsigned tick;
		tick = 0;
		forever begin
			if (hold_offs_done != hold_offs_asked) begin
				hold_offs_done++;
				@(posedge clk);
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				mode    = sink_mode_t'($urandom_range(0, 3));
				run_len = $urandom_range(1, 60);
				repeat (run_len) begin
					@(posedge clk);
					tick++;
					case (mode)
						SINK_OPEN:  out_stall <= 1'b0;
						SINK_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
						SINK_HEAVY: out_stall <= ($urandom_range(0, 1) == 1);
						default:    out_stall <= ((tick % 5) < 2);
					endcase
				end
			end
		end
	end

	// scoreboard: each accepted result transaction against the oldest prediction
	always @(posedge clk) begin : result_check
		result_t want;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_responses.size() == 0) begin
				$error("result transaction with nothing expected: data_out %h", data_out);
				fail_count++;
			end else begin
				want = pending_responses.pop_front();
				if (data_out !== want.data) begin
					$error("data_out: expected %h, got %h", want.data, data_out);
					fail_count++;
				end
				if (found !== want.found) begin
					$error("found: expected %0b, got %0b", want.found, found);
					fail_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, count);
					fail_count++;
				end
			end
		end
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule

FILE: files.f
sv/fqs_pkg.sv
sv/fifo_queue_with_search.sv
verif/tb.sv
